/* rtl/core/queued_mutex_with_waiter_fifo_macros.svh */
// Assertion macros shared by the queued mutex RTL.
// Included by files that carry concurrent checks; depends on nothing.
`ifndef QUEUED_MUTEX_WITH_WAITER_FIFO_MACROS_SVH
`define QUEUED_MUTEX_WITH_WAITER_FIFO_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define QMX_ASSERT_ALWAYS(label, clk_s, rstn_s, cond) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (cond)) \
        else $error("queued mutex: invariant violated");

// A consequence that must hold in the same cycle as its antecedent.
`define QMX_ASSERT_IMPLY(label, clk_s, rstn_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("queued mutex: same-cycle implication violated");

// A consequence that must hold in the cycle after its antecedent.
`define QMX_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("queued mutex: next-cycle implication violated");

`endif

/* rtl/core/qmx_pkg.sv */
// Package for the queued mutex: opcodes, status codes, FSM states and defaults.
// Used by qmx_ram and the top level; depends on nothing.
`timescale 1ns / 1ps

package qmx_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int ID_BITS_DEF     = 8;
    localparam int TICKET_W        = 32;
    localparam int APB_ADDR_W      = 3;
    localparam int APB_DATA_W      = 32;

    // Register index as seen in paddr[2].
    localparam logic [0:0] REG_START_LOCKED = 1'b0;

    typedef enum logic [1:0] {
        OP_LOCK     = 2'd0,
        OP_TRY_LOCK = 2'd1,
        OP_UNLOCK   = 2'd2,
        OP_CANCEL   = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_ACQUIRED   = 3'd0,
        ST_QUEUED     = 3'd1,
        ST_BUSY       = 3'd2,
        ST_FREED      = 3'd3,
        ST_HANDED     = 3'd4,
        ST_WITHDRAWN  = 3'd5,
        ST_FULL       = 3'd6,
        ST_BAD_TICKET = 3'd7
    } status_t;

    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_CANCEL,
        FSM_POP,
        FSM_READ,
        FSM_EMIT
    } fsm_state_t;

endpackage

/* rtl/core/qmx_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on qmx_pkg only for the default sizes.
`timescale 1ns / 1ps

module qmx_ram
    import qmx_pkg::*;
#(
    parameter int WIDTH = ID_BITS_DEF,
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/queued_mutex_with_waiter_fifo.sv */
// Top level of the queued mutex with a FIFO of waiting requesters.
// Depends on qmx_pkg, qmx_ram and queued_mutex_with_waiter_fifo_macros.svh.
`timescale 1ns / 1ps
`include "queued_mutex_with_waiter_fifo_macros.svh"

// Usage
// Each request word on the s_ stream carries an opcode (lock, try-lock, unlock,
// cancel), a requester id and a ticket that only cancel reads. Every request
// produces exactly one result word on the m_ stream: a status, the ticket
// issued to a queued lock, and the id of the waiter that received the lock on
// a handover, flagged by m_tuser.
// The block works on one request at a time. A lock or try-lock goes from idle
// to the emit state, which loads its result into the output register; a cancel
// that withdraws a waiter or reports a bad ticket passes the cancel state first.
// An unlock with waiters pops entries one at a time until it finds a live waiter,
// whose id is read from the RAM in the read state before the handover, or until
// the queue is empty, which frees the mutex. A cancel of an already granted
// ticket passes the cancel state and then acts as an unlock. The next request
// is accepted in the cycle after the result is loaded.
// Results sit in an output register, so a new request is accepted while the
// last result still waits; if the receiver stalls, the next result waits in
// the block and no further request is accepted until it has moved out.
// After reset the mutex is free, the queue is empty and the next ticket is 1.
// Writing start_locked over APB while the queue is empty also sets the mutex to the written value.

module queued_mutex_with_waiter_fifo
    import qmx_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = ID_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    // Request stream.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [1:0] opcode, [9:2] requester_id, [41:10] cancel_ticket, [47:42] zero
    input  logic [47:0]           s_tdata,

    // Result stream.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [2:0] status, [34:3] issued_ticket, [42:35] woken_id, [47:43] zero
    output logic [47:0]           m_tdata,
    // [0] woken_valid
    output logic                  m_tuser,

    // Configuration port.
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Adds an offset to a queue slot and wraps around the queue depth.
    function automatic logic [IDX_W-1:0] slot_after(input logic [IDX_W-1:0] base,
                                                   input logic [IDX_W-1:0] offset);
        logic [IDX_W:0] sum;
        sum = {1'b0, base} + {1'b0, offset};
        if (sum >= (IDX_W + 1)'(QUEUE_DEPTH))
        begin
            sum = sum - (IDX_W + 1)'(QUEUE_DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    // Control state.
    fsm_state_t              state_reg, state_next;
    logic                    held_reg, held_next;
    logic                    start_locked_reg, start_locked_next;
    logic [IDX_W-1:0]        head_reg, head_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [TICKET_W-1:0]     released_reg, released_next;
    logic [TICKET_W-1:0]     ticket_reg, ticket_next;
    logic [QUEUE_DEPTH-1:0]  live_reg, live_next;
    logic                    m_tvalid_reg, m_tvalid_next;

    // Payload registers.
    logic [TICKET_W-1:0]     diff_reg, diff_next;
    status_t                 res_status_reg, res_status_next;
    logic [TICKET_W-1:0]     res_issued_reg, res_issued_next;
    logic [ID_BITS-1:0]      res_woken_reg, res_woken_next;
    status_t                 out_status_reg, out_status_next;
    logic [TICKET_W-1:0]     out_issued_reg, out_issued_next;
    logic [7:0]              out_woken_reg, out_woken_next;
    logic                    out_wvalid_reg, out_wvalid_next;

    // Request fields.
    opcode_t                 in_op;
    logic [ID_BITS-1:0]      in_rid;
    logic [TICKET_W-1:0]     in_ticket;
    logic                    s_fire;

    // Shared decisions.
    logic                    count_zero;
    logic                    count_one;
    logic                    queue_full;
    logic [IDX_W-1:0]        tail_slot;
    logic                    cancel_granted;
    logic [TICKET_W-1:0]     cancel_place;
    logic                    cancel_beyond;
    logic [IDX_W-1:0]        cancel_slot;
    logic [IDX_W-1:0]        live_addr;
    logic                    live_sel;
    logic                    pop_live;
    logic                    out_free;
    logic                    cfg_write;

    // Waiter id memory.
    logic                    ram_we;
    logic [IDX_W-1:0]        ram_waddr;
    logic [ID_BITS-1:0]      ram_wdata;
    logic [IDX_W-1:0]        ram_raddr;
    logic [ID_BITS-1:0]      ram_rdata;

    assign in_op     = opcode_t'(s_tdata[1:0]);
    assign in_rid    = ID_BITS'(s_tdata[9:2]);
    assign in_ticket = s_tdata[41:10];

    // Only one request is in flight; the FSM takes a new one when it is back in idle.
    assign s_tready = (state_reg == FSM_IDLE);
    assign s_fire   = s_tvalid && s_tready;

    assign count_zero = (count_reg == '0);
    assign count_one  = (count_reg == CNT_W'(1));
    assign queue_full = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign tail_slot  = slot_after(head_reg, count_reg[IDX_W-1:0]);

    // A ticket at or behind the released count has already been granted.
    assign cancel_granted = (diff_reg == '0) || diff_reg[TICKET_W-1];
    assign cancel_place   = diff_reg - TICKET_W'(1);
    assign cancel_beyond  = (cancel_place >= TICKET_W'(count_reg));
    assign cancel_slot    = slot_after(head_reg, cancel_place[IDX_W-1:0]);

    // One read of the live bits per cycle: the head while popping, else the cancel slot.
    assign live_addr = (state_reg == FSM_POP) ? head_reg : cancel_slot;
    assign live_sel  = live_reg[live_addr];
    assign pop_live  = (state_reg == FSM_POP) && live_sel;

    assign out_free  = !m_tvalid_reg || m_tready;
    assign cfg_write = psel && penable && pwrite && (paddr[2:2] == REG_START_LOCKED);

    // Id write at enqueue, id read at the head while popping. A slot is never
    // written while a pop is in progress, so no forwarding is needed.
    assign ram_waddr = tail_slot;
    assign ram_wdata = in_rid;
    assign ram_raddr = head_reg;

    qmx_ram #(
        .WIDTH (ID_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_waiter_ids (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FSM_IDLE:
            begin
                if (s_fire)
                begin
                    unique case (in_op)
                        OP_LOCK:     state_next = FSM_EMIT;
                        OP_TRY_LOCK: state_next = FSM_EMIT;
                        OP_UNLOCK:   state_next = count_zero ? FSM_EMIT : FSM_POP;
                        OP_CANCEL:   state_next = FSM_CANCEL;
                        default:     state_next = FSM_IDLE;
                    endcase
                end
            end
            FSM_CANCEL:
            begin
                if (cancel_granted && !count_zero)
                begin
                    state_next = FSM_POP;
                end
                else
                begin
                    state_next = FSM_EMIT;
                end
            end
            FSM_POP:
            begin
                priority if (live_sel)
                begin
                    state_next = FSM_READ;
                end
                else if (count_one)
                begin
                    state_next = FSM_EMIT;
                end
                else
                begin
                    state_next = FSM_POP;
                end
            end
            FSM_READ:
            begin
                state_next = FSM_EMIT;
            end
            FSM_EMIT:
            begin
                if (out_free)
                begin
                    state_next = FSM_IDLE;
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    // Datapath and memory control for each state.
    always_comb
    begin
        held_next         = held_reg;
        start_locked_next = start_locked_reg;
        head_next         = head_reg;
        count_next        = count_reg;
        released_next     = released_reg;
        ticket_next       = ticket_reg;
        live_next         = live_reg;
        diff_next         = diff_reg;
        res_status_next   = res_status_reg;
        res_issued_next   = res_issued_reg;
        res_woken_next    = res_woken_reg;
        ram_we            = 1'b0;

        // Configuration must only arrive while the block is idle; the block does not
        // enforce this. The mutex follows the register only while nobody waits.
        if (cfg_write)
        begin
            start_locked_next = pwdata[0];
            if (count_zero)
            begin
                held_next = pwdata[0];
            end
        end

        unique case (state_reg)
            FSM_IDLE:
            begin
                if (s_fire)
                begin
                    res_issued_next = '0;
                    res_woken_next  = '0;
                    unique case (in_op)
                        OP_LOCK:
                        begin
                            priority if (!held_reg)
                            begin
                                held_next       = 1'b1;
                                res_status_next = ST_ACQUIRED;
                            end
                            else if (queue_full)
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                ram_we               = 1'b1;
                                live_next[tail_slot] = 1'b1;
                                count_next           = count_reg + CNT_W'(1);
                                res_issued_next      = ticket_reg;
                                ticket_next          = ticket_reg + TICKET_W'(1);
                                res_status_next      = ST_QUEUED;
                            end
                        end
                        OP_TRY_LOCK:
                        begin
                            if (!held_reg)
                            begin
                                held_next       = 1'b1;
                                res_status_next = ST_ACQUIRED;
                            end
                            else
                            begin
                                res_status_next = ST_BUSY;
                            end
                        end
                        OP_UNLOCK:
                        begin
                            if (count_zero)
                            begin
                                held_next       = 1'b0;
                                res_status_next = ST_FREED;
                            end
                        end
                        OP_CANCEL:
                        begin
                            diff_next = in_ticket - released_reg;
                        end
                        default:
                        begin
                            res_status_next = res_status_reg;
                        end
                    endcase
                end
            end
            FSM_CANCEL:
            begin
                priority if (cancel_granted)
                begin
                    // Behaves as an unlock; with waiters the pop loop takes over.
                    if (count_zero)
                    begin
                        held_next       = 1'b0;
                        res_status_next = ST_FREED;
                    end
                end
                else if (cancel_beyond || !live_sel)
                begin
                    res_status_next = ST_BAD_TICKET;
                end
                else
                begin
                    live_next[cancel_slot] = 1'b0;
                    res_status_next        = ST_WITHDRAWN;
                end
            end
            FSM_POP:
            begin
                live_next[head_reg] = 1'b0;
                head_next           = slot_after(head_reg, IDX_W'(1));
                count_next          = count_reg - CNT_W'(1);
                released_next       = released_reg + TICKET_W'(1);
                priority if (live_sel)
                begin
                    held_next = 1'b1;
                end
                else if (count_one)
                begin
                    held_next       = 1'b0;
                    res_status_next = ST_FREED;
                end
                else
                begin
                    held_next = held_reg;
                end
            end
            FSM_READ:
            begin
                res_woken_next  = ram_rdata;
                res_status_next = ST_HANDED;
            end
            FSM_EMIT:
            begin
                res_status_next = res_status_reg;
            end
            default:
            begin
                res_status_next = res_status_reg;
            end
        endcase
    end

    // Output register: loads the pending result when the slot is free.
    always_comb
    begin
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_issued_next = out_issued_reg;
        out_woken_next  = out_woken_reg;
        out_wvalid_next = out_wvalid_reg;
        if ((state_reg == FSM_EMIT) && out_free)
        begin
            m_tvalid_next   = 1'b1;
            out_status_next = res_status_reg;
            out_issued_next = res_issued_reg;
            out_wvalid_next = (res_status_reg == ST_HANDED);
            out_woken_next  = (res_status_reg == ST_HANDED) ? 8'(res_woken_reg) : 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= FSM_IDLE;
            held_reg         <= 1'b0;
            start_locked_reg <= 1'b0;
            head_reg         <= '0;
            count_reg        <= '0;
            released_reg     <= '0;
            ticket_reg       <= TICKET_W'(1);
            live_reg         <= '0;
            m_tvalid_reg     <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            held_reg         <= held_next;
            start_locked_reg <= start_locked_next;
            head_reg         <= head_next;
            count_reg        <= count_next;
            released_reg     <= released_next;
            ticket_reg       <= ticket_next;
            live_reg         <= live_next;
            m_tvalid_reg     <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        diff_reg       <= diff_next;
        res_status_reg <= res_status_next;
        res_issued_reg <= res_issued_next;
        res_woken_reg  <= res_woken_next;
        out_status_reg <= out_status_next;
        out_issued_reg <= out_issued_next;
        out_woken_reg  <= out_woken_next;
        out_wvalid_reg <= out_wvalid_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'd0, out_woken_reg, out_issued_reg, out_status_reg};
    assign m_tuser  = out_wvalid_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[2:2] == REG_START_LOCKED) ? APB_DATA_W'(start_locked_reg) : '0;

    // The waiter count never exceeds the queue depth.
    `QMX_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= CNT_W'(QUEUE_DEPTH))
    // Anyone waiting means somebody holds the mutex.
    `QMX_ASSERT_IMPLY(a_wait_held, clk, rst_n, (state_reg == FSM_IDLE) && !count_zero, held_reg)
    // The pop loop only runs over a non-empty queue.
    `QMX_ASSERT_IMPLY(a_pop_nonempty, clk, rst_n, state_reg == FSM_POP, !count_zero)
    // Finding a live waiter at the head leads to the id read and a handover.
    `QMX_ASSERT_NEXT(a_pop_handover, clk, rst_n, pop_live, (state_reg == FSM_READ) && held_reg)

endmodule
